>>> design/rslb_pkg.sv
package rslb_pkg;

   // Display geometry and blink timing.
   localparam int NUM_LEDS          = 8;
   localparam int BAR_CELLS         = 20;
   localparam int BLINK_HALF_PERIOD = 3;
   localparam int BAR_HALF          = BAR_CELLS / 2;

   // Field widths.
   localparam int RPM_W   = 16;
   localparam int PCT_W   = 8;
   localparam int THR_W   = 64;
   localparam int CNT_W   = $clog2(NUM_LEDS + 1);
   localparam int PHASE_W = $clog2(2 * BLINK_HALF_PERIOD);

   // Load in unsigned Q9.8, saturating at the all-ones code.
   localparam int LOAD_W = 17;
   localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

   // Load dividend is rpm * 25600, built as rpm * (2^14 + 2^13 + 2^10).
   localparam int PROD_W = RPM_W + 15;

   // Bar percent is clamped at 100, so seven quotient bits suffice.
   localparam int PCT_FULL   = 100;
   localparam int PCTQ_W     = 7;
   localparam int DIV1_STEPS = LOAD_W;
   localparam int DIV2_STEPS = PCTQ_W;
   localparam int STEP_W     = $clog2(DIV1_STEPS + 1);

   // Rounding of the cell count: (pct * 2 * cells + 100) / 200.
   localparam int ROUND_DEN  = 200;
   localparam int ROUND_BIAS = 100;
   localparam int BSUM_W     = $clog2(PCT_FULL * 2 * BAR_CELLS + ROUND_BIAS + 1);

   // Register reset values.
   localparam logic [PCT_W-1:0] RED_ZONE_RESET   = 8'd95;
   localparam logic [PCT_W-1:0] SHIFT_ZONE_RESET = 8'd80;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      CSR_RED_ZONE   = 2'd0,
      CSR_SHIFT_ZONE = 2'd1,
      CSR_LED_THR    = 2'd2
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_PREP1  = 7'b0000010,
      S_CHECK  = 7'b0000100,
      S_DIV    = 7'b0001000,
      S_PREP2  = 7'b0010000,
      S_SCALE  = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

   // Mask with the lowest n LEDs set.
   function automatic logic [NUM_LEDS-1:0] led_ones(input logic [CNT_W-1:0] n);
      logic [NUM_LEDS-1:0] m;
      m = '0;
      for (int i = 0; i < NUM_LEDS; i++) begin
         m[i] = (CNT_W'(i) < n);
      end
      return m;
   endfunction

endpackage

>>> design/rpm_shift_light_bar_core.sv
// Shift-light and rpm bar controller, one result word per display frame.
//
// Request channel (req_): engine, idle and top rpm plus the bar style, taken
// with valid and ready. Response channel (rsp_): bar mask, LED mask, the
// all-last-colour flag, the red-zone flag and the ladder LED count.
// Configuration channel (csr_): index 0 red zone percent, 1 shift zone
// percent, 2 the eight LED thresholds; always ready, other indexes ignored.
//
// The processing time of a word is set by one shared restoring divider
// that produces one quotient bit a cycle: 17 steps for the Q9.8 load and
// 7 steps for the bar percent, plus setup, overflow check, scaling and
// finishing states. A new word is accepted only once the sequencer is back
// in idle after the previous result is written to the output register, so
// a word is not taken until the previous one is through the divider.
//
// The finished result sits in an output register; the next word is taken
// and computed while it waits. If the receiver still stalls when the next
// result is ready, the sequencer holds it until the register frees up.
// Synchronous reset restores the register defaults, clears the red-zone
// flag and the blink phase, and empties the pipeline.
module rpm_shift_light_bar_core
   import rslb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [RPM_W-1:0]     req_engine_rpm,
   input  logic [RPM_W-1:0]     req_idle_rpm,
   input  logic [RPM_W-1:0]     req_top_rpm,
   input  logic                 req_converging_style,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [BAR_CELLS-1:0] rsp_bar_mask,
   output logic [NUM_LEDS-1:0]  rsp_led_mask,
   output logic                 rsp_leds_all_last_colour,
   output logic                 rsp_in_red_zone,
   output logic [CNT_W-1:0]     rsp_led_count,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [THR_W-1:0]     csr_data
);

   // Control and configuration state.
   state_type           state_ff, state_in;
   logic                second_ff, second_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                red_flag_ff, red_flag_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [PCT_W-1:0]    red_zone_ff, red_zone_in;
   logic [PCT_W-1:0]    shift_zone_ff, shift_zone_in;
   logic [THR_W-1:0]    led_thr_ff, led_thr_in;

   // Datapath registers.
   logic [RPM_W-1:0]    num_ff, num_in;
   logic [RPM_W-1:0]    den_ff, den_in;
   logic                ovf_ff, ovf_in;
   logic [RPM_W-1:0]    rem_ff, rem_in;
   logic [LOAD_W-1:0]   dvd_ff, dvd_in;
   logic [LOAD_W-1:0]   load_ff, load_in;
   logic [PCTQ_W-1:0]   pct_ff, pct_in;
   logic                conv_ff, conv_in;

   // Output register.
   logic [BAR_CELLS-1:0] bar_ff, bar_in;
   logic [NUM_LEDS-1:0]  leds_ff, leds_in;
   logic                 all_last_ff, all_last_in;
   logic                 red_out_ff, red_out_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   // Combinational helpers.
   logic [PROD_W-1:0]    prod;
   logic [RPM_W+1:0]     diff;
   logic                 qbit;
   logic [LOAD_W-1:0]    load_sel;
   logic [LOAD_W+7:0]    scaled;
   logic [LOAD_W-1:0]    n2;
   logic                 show;
   logic                 hit;
   logic                 run;
   logic [CNT_W-1:0]     ladder_count;
   logic [NUM_LEDS-1:0]  ladder_mask;
   logic [BSUM_W-1:0]    lin_sum;
   logic [BSUM_W-1:0]    conv_sum;
   logic [BAR_CELLS-1:0] bar_lin;
   logic [BAR_CELLS-1:0] bar_conv;
   logic                 out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Dividend of the load division and one restoring step of the divider.
   assign prod = (PROD_W'(num_ff) << 14) + (PROD_W'(num_ff) << 13)
               + (PROD_W'(num_ff) << 10);
   assign diff = {1'b0, rem_ff, dvd_ff[LOAD_W-1]} - {2'b00, den_ff};
   assign qbit = !diff[RPM_W+1];

   // Load with saturation, and the bar percent dividend scaled down by 256.
   // Adding the shift zone and dividing by twice it rounds half up.
   assign load_sel = ovf_ff ? LOAD_MAX : dvd_ff;
   assign scaled   = ((LOAD_W+8)'(load_sel) << 7) + ((LOAD_W+8)'(load_sel) << 6)
                   + ((LOAD_W+8)'(load_sel) << 3);
   assign n2       = LOAD_W'(scaled[LOAD_W+7:8]) + LOAD_W'(shift_zone_ff);

   // Red-zone hysteresis and blink phase.
   assign show = (phase_ff < PHASE_W'(BLINK_HALF_PERIOD));
   assign hit  = (load_ff >= LOAD_W'({red_zone_ff, 8'h00}))
              || (red_flag_ff && (load_ff >= LOAD_W'({shift_zone_ff, 8'h00})));

   // Threshold ladder: stops at the first LED whose threshold is above load.
   always_comb begin
      run          = 1'b1;
      ladder_count = '0;
      for (int i = 0; i < NUM_LEDS; i++) begin
         if (run && (load_ff >= LOAD_W'({led_thr_ff[8*i +: 8], 8'h00}))) begin
            ladder_count = CNT_W'(i + 1);
         end else begin
            run = 1'b0;
         end
      end
      ladder_mask = led_ones(ladder_count);
   end

   // Bar cells: cell k lit when the rounded cell count exceeds k.
   assign lin_sum  = BSUM_W'(pct_ff) * BSUM_W'(2 * BAR_CELLS) + BSUM_W'(ROUND_BIAS);
   assign conv_sum = BSUM_W'(pct_ff) * BSUM_W'(2 * BAR_HALF) + BSUM_W'(ROUND_BIAS);

   always_comb begin
      bar_lin  = '0;
      bar_conv = '0;
      for (int i = 0; i < BAR_CELLS; i++) begin
         bar_lin[i] = (lin_sum >= BSUM_W'((i + 1) * ROUND_DEN));
      end
      for (int i = 0; i < BAR_HALF; i++) begin
         if (conv_sum >= BSUM_W'((i + 1) * ROUND_DEN)) begin
            bar_conv[i]               = 1'b1;
            bar_conv[BAR_CELLS-1-i]   = 1'b1;
         end
      end
   end

   // Sequencer and datapath next state.
   always_comb begin
      state_in      = state_ff;
      second_in     = second_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff;
      red_flag_in   = red_flag_ff;
      phase_in      = phase_ff;
      red_zone_in   = red_zone_ff;
      shift_zone_in = shift_zone_ff;
      led_thr_in    = led_thr_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      ovf_in        = ovf_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      load_in       = load_ff;
      pct_in        = pct_ff;
      conv_in       = conv_ff;
      bar_in        = bar_ff;
      leds_in       = leds_ff;
      all_last_in   = all_last_ff;
      red_out_in    = red_out_ff;
      count_in      = count_ff;

      // The response register empties when the receiver takes the word.
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Configuration writes.
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_RED_ZONE:   red_zone_in   = csr_data[PCT_W-1:0];
            CSR_SHIFT_ZONE: shift_zone_in = csr_data[PCT_W-1:0];
            CSR_LED_THR:    led_thr_in    = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               num_in   = (req_engine_rpm > req_idle_rpm) ?
                          req_engine_rpm - req_idle_rpm : '0;
               den_in   = req_top_rpm - req_idle_rpm;
               ovf_in   = (req_top_rpm <= req_idle_rpm);
               conv_in  = req_converging_style;
               state_in = S_PREP1;
            end
         end
         S_PREP1: begin
            rem_in    = RPM_W'(prod[PROD_W-1:LOAD_W]);
            dvd_in    = prod[LOAD_W-1:0];
            step_in   = STEP_W'(DIV1_STEPS);
            second_in = 1'b0;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            // A quotient too wide for the result saturates.
            ovf_in   = ovf_ff || (rem_ff >= den_ff);
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in  = qbit ? diff[RPM_W-1:0] : {rem_ff[RPM_W-2:0], dvd_ff[LOAD_W-1]};
            dvd_in  = {dvd_ff[LOAD_W-2:0], qbit};
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               state_in = second_ff ? S_SCALE : S_PREP2;
            end
         end
         S_PREP2: begin
            load_in   = load_sel;
            rem_in    = RPM_W'(n2[LOAD_W-1:PCTQ_W]);
            dvd_in    = {n2[PCTQ_W-1:0], (LOAD_W-PCTQ_W)'(0)};
            den_in    = RPM_W'({shift_zone_ff, 1'b0});
            ovf_in    = 1'b0;
            step_in   = STEP_W'(DIV2_STEPS);
            second_in = 1'b1;
            state_in  = S_CHECK;
         end
         S_SCALE: begin
            // Percent of the shift zone, clamped at a full bar.
            if (ovf_ff || (dvd_ff[PCTQ_W-1:0] > PCTQ_W'(PCT_FULL))) begin
               pct_in = PCTQ_W'(PCT_FULL);
            end else begin
               pct_in = dvd_ff[PCTQ_W-1:0];
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               red_flag_in  = hit;
               red_out_in   = hit;
               phase_in     = (phase_ff == PHASE_W'(2 * BLINK_HALF_PERIOD - 1)) ?
                              '0 : phase_ff + 1'b1;
               if (hit) begin
                  bar_in      = show ? '1 : '0;
                  leds_in     = show ? '1 : '0;
                  all_last_in = show;
                  count_in    = '0;
               end else begin
                  bar_in      = conv_ff ? bar_conv : bar_lin;
                  leds_in     = ladder_mask;
                  all_last_in = 1'b0;
                  count_in    = ladder_count;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         second_ff     <= 1'b0;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         red_flag_ff   <= 1'b0;
         phase_ff      <= '0;
         red_zone_ff   <= RED_ZONE_RESET;
         shift_zone_ff <= SHIFT_ZONE_RESET;
         led_thr_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         second_ff     <= second_in;
         step_ff       <= step_in;
         rsp_valid_ff  <= rsp_valid_in;
         red_flag_ff   <= red_flag_in;
         phase_ff      <= phase_in;
         red_zone_ff   <= red_zone_in;
         shift_zone_ff <= shift_zone_in;
         led_thr_ff    <= led_thr_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      den_ff      <= den_in;
      ovf_ff      <= ovf_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      load_ff     <= load_in;
      pct_ff      <= pct_in;
      conv_ff     <= conv_in;
      bar_ff      <= bar_in;
      leds_ff     <= leds_in;
      all_last_ff <= all_last_in;
      red_out_ff  <= red_out_in;
      count_ff    <= count_in;
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_bar_mask             = bar_ff;
   assign rsp_led_mask             = leds_ff;
   assign rsp_leds_all_last_colour = all_last_ff;
   assign rsp_in_red_zone          = red_out_ff;
   assign rsp_led_count            = count_ff;

   // An accepted word always starts the load division setup.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_PREP1)
      else $error("accepted word did not start the divider setup");

   // The blink phase never leaves its period.
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PHASE_W'(2 * BLINK_HALF_PERIOD - 1))
      else $error("blink phase out of range");

   // The all-last-colour flag only appears inside the red zone.
   a_all_last_red: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_leds_all_last_colour |-> rsp_in_red_zone)
      else $error("all-last-colour outside the red zone");

   // Outside the red zone the LED mask follows the ladder count.
   a_ladder_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_red_zone |-> rsp_led_mask == led_ones(rsp_led_count))
      else $error("LED mask does not match the ladder count");

   // Inside the red zone the ladder count is zero.
   a_red_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_red_zone |-> rsp_led_count == '0)
      else $error("nonzero LED count in the red zone");

endmodule
